/* design/gdt_pkg.sv */
`default_nettype none

package gdt_pkg;

	localparam int unsigned DEF_MAX_VERTICES  = 16;
	localparam int unsigned DEF_MAX_NEIGHBORS = 16;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned VIDX_W  = 4;
	localparam int unsigned LABEL_W = 8;
	localparam int unsigned COUNT_W = 5;

	// vertex indices are four bits wide, so no more than this many vertices are reachable
	localparam int unsigned VIDX_LIMIT = 16;

	localparam logic [COUNT_W-1:0] VCOUNT_RESET = 5'd1;

	localparam logic [KIND_W-1:0] KIND_SET_LABEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_NBR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN       = 2'd2;

	localparam logic ORDER_DFS = 1'b0;
	localparam logic ORDER_BFS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DFS_ROOT,
		ST_DFS_FETCH,
		ST_DFS_MATCH,
		ST_DFS_POP,
		ST_BFS_SEED,
		ST_BFS_DEQ,
		ST_BFS_DEQW,
		ST_BFS_FETCH,
		ST_BFS_MATCH,
		ST_FINISH
	} gdt_state_t;

	typedef struct packed {
		logic                set_label;
		logic                add_nbr;
		logic [VIDX_W-1:0]   vertex;
		logic [LABEL_W-1:0]  label;
	} gdt_load_t;

	typedef struct packed {
		logic emit;
		logic finish;
	} gdt_emit_t;

endpackage

`default_nettype wire

/* design/gdt_graph_store.sv */
`default_nettype none

module gdt_graph_store #(
	parameter int unsigned MAX_VERTICES  = gdt_pkg::DEF_MAX_VERTICES,
	parameter int unsigned MAX_NEIGHBORS = gdt_pkg::DEF_MAX_NEIGHBORS,
	localparam int unsigned NUM_V = (MAX_VERTICES < gdt_pkg::VIDX_LIMIT) ?
		MAX_VERTICES : gdt_pkg::VIDX_LIMIT,
	localparam int unsigned VW  = $clog2(NUM_V),
	localparam int unsigned KW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
	localparam int unsigned KCW = $clog2(MAX_NEIGHBORS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gdt_pkg::gdt_load_t            load,
	input  wire logic                          nbr_rd_en,
	input  wire logic [VW-1:0]                 cur_vtx,
	input  wire logic [KW-1:0]                 nbr_rd_k,
	input  wire logic [VW-1:0]                 lbl_vtx,
	output logic [KCW-1:0]                     nbr_cnt,
	output logic [NUM_V-1:0]                   match_mask,
	output logic [gdt_pkg::LABEL_W-1:0]        lbl_data
);
	import gdt_pkg::*;

	localparam int unsigned DEPTH = NUM_V * MAX_NEIGHBORS;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [LABEL_W-1:0] vlabel_q [NUM_V];
	logic [KCW-1:0]     ncnt_q   [NUM_V];
	logic [LABEL_W-1:0] nbr_mem  [DEPTH];
	logic [LABEL_W-1:0] nbr_rd_q;

	logic          in_range;
	logic [VW-1:0] ld_v;
	logic          ld_full;
	logic          nbr_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign in_range = ({1'b0, load.vertex} < (VIDX_W + 1)'(NUM_V));
	assign ld_v     = load.vertex[VW-1:0];
	assign ld_full  = (ncnt_q[ld_v] == KCW'(MAX_NEIGHBORS));
	assign nbr_we   = load.add_nbr && in_range && !ld_full;
	assign waddr    = AW'(ld_v) * AW'(MAX_NEIGHBORS) + AW'(ncnt_q[ld_v]);
	assign raddr    = AW'(cur_vtx) * AW'(MAX_NEIGHBORS) + AW'(nbr_rd_k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_V; i++) begin
				ncnt_q[i] <= '0;
			end
		end else if (load.set_label && in_range) begin
			ncnt_q[ld_v] <= '0;
		end else if (nbr_we) begin
			ncnt_q[ld_v] <= ncnt_q[ld_v] + KCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load.set_label && in_range) begin
			vlabel_q[ld_v] <= load.label;
		end
	end

	// neighbor list store: one write port for loads, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (nbr_we) begin
			nbr_mem[waddr] <= load.label;
		end
		if (nbr_rd_en) begin
			nbr_rd_q <= nbr_mem[raddr];
		end
	end

	for (genvar j = 0; j < NUM_V; j++) begin : g_match
		assign match_mask[j] = (vlabel_q[j] == nbr_rd_q);
	end

	assign nbr_cnt  = ncnt_q[cur_vtx];
	assign lbl_data = vlabel_q[lbl_vtx];

endmodule

`default_nettype wire

/* design/gdt_walker.sv */
`default_nettype none

module gdt_walker #(
	parameter int unsigned MAX_VERTICES  = gdt_pkg::DEF_MAX_VERTICES,
	parameter int unsigned MAX_NEIGHBORS = gdt_pkg::DEF_MAX_NEIGHBORS,
	localparam int unsigned NUM_V = (MAX_VERTICES < gdt_pkg::VIDX_LIMIT) ?
		MAX_VERTICES : gdt_pkg::VIDX_LIMIT,
	localparam int unsigned VW  = $clog2(NUM_V),
	localparam int unsigned KW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
	localparam int unsigned KCW = $clog2(MAX_NEIGHBORS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          run_go,
	input  wire logic                          run_order,
	input  wire logic [gdt_pkg::COUNT_W-1:0]   run_count,
	input  wire logic [NUM_V-1:0]              match_mask,
	input  wire logic [KCW-1:0]                nbr_cnt,
	output logic                               busy,
	output logic                               nbr_rd_en,
	output logic [VW-1:0]                      cur_vtx,
	output logic [KW-1:0]                      nbr_rd_k,
	output gdt_pkg::gdt_emit_t                 emit,
	output logic [VW-1:0]                      emit_vtx
);
	import gdt_pkg::*;

	localparam int unsigned NCW = $clog2(NUM_V + 1);

	gdt_state_t state_q, state_d;

	logic [NUM_V-1:0] visited_q;
	logic [NUM_V-1:0] inuse;
	logic [NUM_V-1:0] seed_mask;
	logic [NUM_V-1:0] cand_mask;
	logic [VW-1:0]    seed_lo;
	logic [VW-1:0]    cand_lo;

	logic [NCW-1:0] n_q;
	logic [NCW-1:0] cnt_eff;
	logic [NCW-1:0] sp_q;
	logic [NCW-1:0] sp_m1;
	logic [NCW-1:0] head_q;
	logic [NCW-1:0] tail_q;
	logic [VW-1:0]  cur_v_q;
	logic [KCW-1:0] cur_k_q;
	logic           k_done;

	// pending store: DFS frames {vertex, neighbor slot} or BFS queue entries
	logic [VW+KW-1:0] pend_mem [NUM_V];
	logic [VW+KW-1:0] pend_rd_q;
	logic [VW+KW-1:0] pend_wdata;
	logic [VW-1:0]    pend_waddr;
	logic [VW-1:0]    pend_raddr;
	logic             pend_we;
	logic             pend_rd_en;

	for (genvar j = 0; j < NUM_V; j++) begin : g_inuse
		assign inuse[j] = (NCW'(j) < n_q);
	end

	assign seed_mask = ~visited_q & inuse;
	assign cand_mask = seed_mask & match_mask;
	assign cnt_eff   = (run_count > COUNT_W'(NUM_V)) ? NCW'(NUM_V) : NCW'(run_count);
	assign k_done    = (cur_k_q >= nbr_cnt);
	assign sp_m1     = sp_q - NCW'(1);

	always_comb begin
		seed_lo = '0;
		cand_lo = '0;
		for (int i = NUM_V - 1; i >= 0; i--) begin
			if (seed_mask[i]) begin
				seed_lo = VW'(i);
			end
			if (cand_mask[i]) begin
				cand_lo = VW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (run_go) begin
					if (cnt_eff == '0) begin
						state_d = ST_FINISH;
					end else if (run_order == ORDER_DFS) begin
						state_d = ST_DFS_ROOT;
					end else begin
						state_d = ST_BFS_SEED;
					end
				end
			end
			ST_DFS_ROOT:  state_d = ST_DFS_FETCH;
			ST_DFS_FETCH: begin
				if (!k_done) begin
					state_d = ST_DFS_MATCH;
				end else if (sp_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DFS_POP;
				end
			end
			ST_DFS_MATCH: state_d = ST_DFS_FETCH;
			ST_DFS_POP:   state_d = ST_DFS_FETCH;
			ST_BFS_SEED:  state_d = (seed_mask == '0) ? ST_FINISH : ST_BFS_DEQ;
			ST_BFS_DEQ:   state_d = (head_q == tail_q) ? ST_BFS_SEED : ST_BFS_DEQW;
			ST_BFS_DEQW:  state_d = ST_BFS_FETCH;
			ST_BFS_FETCH: state_d = k_done ? ST_BFS_DEQ : ST_BFS_MATCH;
			ST_BFS_MATCH: state_d = (cand_mask == '0) ? ST_BFS_FETCH : ST_BFS_MATCH;
			ST_FINISH:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		nbr_rd_en  = 1'b0;
		pend_rd_en = 1'b0;
		pend_raddr = head_q[VW-1:0];
		pend_we    = 1'b0;
		pend_waddr = tail_q[VW-1:0];
		pend_wdata = {cand_lo, {KW{1'b0}}};
		emit       = '0;
		emit_vtx   = cand_lo;
		unique case (state_q)
			ST_DFS_ROOT: begin
				emit.emit = 1'b1;
				emit_vtx  = '0;
			end
			ST_DFS_FETCH: begin
				if (!k_done) begin
					nbr_rd_en = 1'b1;
				end else if (sp_q != '0) begin
					pend_rd_en = 1'b1;
					pend_raddr = sp_m1[VW-1:0];
				end
			end
			ST_DFS_MATCH: begin
				// descend into the lowest unvisited match, park the current frame
				if (cand_mask != '0) begin
					emit.emit  = 1'b1;
					pend_we    = 1'b1;
					pend_waddr = sp_q[VW-1:0];
					pend_wdata = {cur_v_q, cur_k_q[KW-1:0]};
				end
			end
			ST_BFS_SEED: begin
				if (seed_mask != '0) begin
					emit.emit  = 1'b1;
					emit_vtx   = seed_lo;
					pend_we    = 1'b1;
					pend_wdata = {seed_lo, {KW{1'b0}}};
				end
			end
			ST_BFS_DEQ: begin
				pend_rd_en = (head_q != tail_q);
			end
			ST_BFS_FETCH: begin
				nbr_rd_en = !k_done;
			end
			ST_BFS_MATCH: begin
				if (cand_mask != '0) begin
					emit.emit = 1'b1;
					pend_we   = 1'b1;
				end
			end
			ST_FINISH: begin
				emit.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			visited_q <= '0;
			n_q       <= '0;
			sp_q      <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			cur_v_q   <= '0;
			cur_k_q   <= '0;
		end else begin
			state_q <= state_d;
			if (emit.emit) begin
				visited_q[emit_vtx] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (run_go) begin
						visited_q <= '0;
						n_q       <= cnt_eff;
						sp_q      <= '0;
						head_q    <= '0;
						tail_q    <= '0;
					end
				end
				ST_DFS_ROOT: begin
					cur_v_q <= '0;
					cur_k_q <= '0;
				end
				ST_DFS_MATCH: begin
					if (cand_mask != '0) begin
						sp_q    <= sp_q + NCW'(1);
						cur_v_q <= cand_lo;
						cur_k_q <= '0;
					end else begin
						cur_k_q <= cur_k_q + KCW'(1);
					end
				end
				ST_DFS_POP: begin
					// resume the parent at the same slot: more labels there may still match
					cur_v_q <= pend_rd_q[VW+KW-1:KW];
					cur_k_q <= KCW'(pend_rd_q[KW-1:0]);
					sp_q    <= sp_m1;
				end
				ST_BFS_SEED: begin
					if (seed_mask != '0) begin
						tail_q <= tail_q + NCW'(1);
					end
				end
				ST_BFS_DEQ: begin
					if (head_q != tail_q) begin
						head_q <= head_q + NCW'(1);
					end
				end
				ST_BFS_DEQW: begin
					cur_v_q <= pend_rd_q[VW+KW-1:KW];
					cur_k_q <= '0;
				end
				ST_BFS_MATCH: begin
					if (cand_mask != '0) begin
						tail_q <= tail_q + NCW'(1);
					end else begin
						cur_k_q <= cur_k_q + KCW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_waddr] <= pend_wdata;
		end
		if (pend_rd_en) begin
			pend_rd_q <= pend_mem[pend_raddr];
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign cur_vtx  = cur_v_q;
	assign nbr_rd_k = cur_k_q[KW-1:0];

endmodule

`default_nettype wire

/* design/gdt_result_out.sv */
`default_nettype none

module gdt_result_out #(
	parameter int unsigned MAX_VERTICES = gdt_pkg::DEF_MAX_VERTICES,
	localparam int unsigned NUM_V = (MAX_VERTICES < gdt_pkg::VIDX_LIMIT) ?
		MAX_VERTICES : gdt_pkg::VIDX_LIMIT,
	localparam int unsigned VW = $clog2(NUM_V)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gdt_pkg::gdt_emit_t            emit,
	input  wire logic [VW-1:0]                 emit_vtx,
	input  wire logic [gdt_pkg::LABEL_W-1:0]   emit_label,
	output logic                               strobe,
	output logic [gdt_pkg::LABEL_W-1:0]        visited_label,
	output logic [gdt_pkg::VIDX_W-1:0]         visited_index,
	output logic                               last
);
	import gdt_pkg::*;

	logic               pend_vld_q;
	logic [LABEL_W-1:0] pend_lbl_q;
	logic [VIDX_W-1:0]  pend_idx_q;
	logic               out_stb_q;
	logic               out_last_q;
	logic [LABEL_W-1:0] out_lbl_q;
	logic [VIDX_W-1:0]  out_idx_q;

	// hold each visit back by one so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_stb_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			out_stb_q  <= pend_vld_q && (emit.emit || emit.finish);
			out_last_q <= emit.finish;
			if (emit.emit) begin
				pend_vld_q <= 1'b1;
			end else if (emit.finish) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.emit) begin
			pend_lbl_q <= emit_label;
			pend_idx_q <= VIDX_W'(emit_vtx);
		end
		if (pend_vld_q && (emit.emit || emit.finish)) begin
			out_lbl_q <= pend_lbl_q;
			out_idx_q <= pend_idx_q;
		end
	end

	assign strobe        = out_stb_q;
	assign last          = out_last_q;
	assign visited_label = out_lbl_q;
	assign visited_index = out_idx_q;

endmodule

`default_nettype wire

/* design/graph_dfs_bfs_traversal.sv */
// Graph traversal engine. Load items (kind 0 sets a vertex label and clears its neighbor
// list, kind 1 appends a neighbor label) are taken one per cycle while busy is low. A run
// item (kind 2) raises busy and emits every visited vertex as one beat on strobe with
// visited_label, visited_index and last on the final beat; the receiver cannot stall, so
// each beat is there for exactly one cycle. A depth first run visits the root, then
// fetches and matches each neighbor-list slot examined (a slot is examined again on each
// return to it), pops back to a parent vertex when a list is done, and winds down; a
// breadth first run fetches and matches each slot, with an extra match step per vertex
// found there, dequeues each queued vertex, starts afresh from each unvisited seed vertex
// and winds down. The pace is set by the single read port of the neighbor-list memory,
// read once per slot visit. Each beat trails the walk by one visit; the last beat comes
// out in the cycle after the walk ends, the same cycle in which busy falls. A run with
// vertex_count 0 gives no beat. The user must write vertex_count through cfg_we/cfg_data
// only while busy is low; the block itself does not enforce it.
`default_nettype none

module graph_dfs_bfs_traversal #(
	parameter int unsigned MAX_VERTICES  = gdt_pkg::DEF_MAX_VERTICES,
	parameter int unsigned MAX_NEIGHBORS = gdt_pkg::DEF_MAX_NEIGHBORS,
	localparam int unsigned NUM_V = (MAX_VERTICES < gdt_pkg::VIDX_LIMIT) ?
		MAX_VERTICES : gdt_pkg::VIDX_LIMIT,
	localparam int unsigned VW  = $clog2(NUM_V),
	localparam int unsigned KW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
	localparam int unsigned KCW = $clog2(MAX_NEIGHBORS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [gdt_pkg::KIND_W-1:0]    kind,
	input  wire logic [gdt_pkg::VIDX_W-1:0]    vertex,
	input  wire logic [gdt_pkg::LABEL_W-1:0]   label,
	input  wire logic                          order,
	input  wire logic                          cfg_we,
	input  wire logic [gdt_pkg::COUNT_W-1:0]   cfg_data,
	output logic                               strobe,
	output logic [gdt_pkg::LABEL_W-1:0]        visited_label,
	output logic [gdt_pkg::VIDX_W-1:0]         visited_index,
	output logic                               last
);
	import gdt_pkg::*;

	logic [COUNT_W-1:0] vertex_count_q;
	logic               accept;
	logic               run_go;
	gdt_load_t          load;
	gdt_emit_t          emit;

	logic               nbr_rd_en;
	logic [VW-1:0]      cur_vtx;
	logic [KW-1:0]      nbr_rd_k;
	logic [KCW-1:0]     nbr_cnt;
	logic [NUM_V-1:0]   match_mask;
	logic [VW-1:0]      emit_vtx;
	logic [LABEL_W-1:0] emit_label;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_data;
		end
	end

	assign accept         = start && !busy;
	assign run_go         = accept && (kind == KIND_RUN);
	assign load.set_label = accept && (kind == KIND_SET_LABEL);
	assign load.add_nbr   = accept && (kind == KIND_ADD_NBR);
	assign load.vertex    = vertex;
	assign load.label     = label;

	gdt_graph_store #(
		.MAX_VERTICES  (MAX_VERTICES),
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.nbr_rd_en  (nbr_rd_en),
		.cur_vtx    (cur_vtx),
		.nbr_rd_k   (nbr_rd_k),
		.lbl_vtx    (emit_vtx),
		.nbr_cnt    (nbr_cnt),
		.match_mask (match_mask),
		.lbl_data   (emit_label)
	);

	gdt_walker #(
		.MAX_VERTICES  (MAX_VERTICES),
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_go     (run_go),
		.run_order  (order),
		.run_count  (vertex_count_q),
		.match_mask (match_mask),
		.nbr_cnt    (nbr_cnt),
		.busy       (busy),
		.nbr_rd_en  (nbr_rd_en),
		.cur_vtx    (cur_vtx),
		.nbr_rd_k   (nbr_rd_k),
		.emit       (emit),
		.emit_vtx   (emit_vtx)
	);

	gdt_result_out #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit),
		.emit_vtx      (emit_vtx),
		.emit_label    (emit_label),
		.strobe        (strobe),
		.visited_label (visited_label),
		.visited_index (visited_index),
		.last          (last)
	);

	a_beat_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without a run in progress");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final beat after the run ended");

	a_nothing_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("beat follows the final beat");

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_RUN)) |=> busy)
		else $error("run item accepted but engine stayed idle");

endmodule

`default_nettype wire
